// File: hdl/rspe_pkg.sv
// shared types, constants and GF(256) arithmetic for the reed-solomon parity encoder
// no dependencies
package rspe_pkg;

	localparam int BYTE_W = 8;
	localparam int EC_W = 6;
	localparam logic [BYTE_W:0] GF_POLY = 9'h11D;
	localparam int EC_RESET = 10;
	localparam logic REG_EC = 1'b0;

	typedef logic [BYTE_W-1:0] gf_t;

	// status of the input stage toward the parity buffer and the stream port
	typedef struct packed {
		logic load;
		logic stall;
	} lfsr_stat_t;

	// multiply by alpha
	function automatic gf_t gf_xtime(input gf_t a);
		logic [BYTE_W:0] x;
		x = {a, 1'b0};
		if (x[BYTE_W]) x = x ^ GF_POLY;
		return x[BYTE_W-1:0];
	endfunction

	function automatic gf_t gf_mul(input gf_t a, input gf_t b);
		gf_t x;
		gf_t acc;
		x = a;
		acc = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			if (b[k]) acc = acc ^ x;
			x = gf_xtime(x);
		end
		return acc;
	endfunction

endpackage

// File: hdl/rspe_genbuild.sv
// generator polynomial builder: multiplies in one (x + alpha^k) factor per cycle
// depends on rspe_pkg
module rspe_genbuild import rspe_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [EC_W-1:0] ec,
	output logic            busy,
	output gf_t             gen [MAX_PARITY]
);

	logic            busy_q;
	logic [EC_W-1:0] deg_q;
	gf_t             root_q;
	gf_t             gen_q [MAX_PARITY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			deg_q  <= '0;
			root_q <= gf_t'(1);
			for (int i = 0; i < MAX_PARITY; i++) gen_q[i] <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			deg_q  <= '0;
			root_q <= gf_t'(1);
			for (int i = 0; i < MAX_PARITY; i++) gen_q[i] <= '0;
		end else if (busy_q) begin
			if (deg_q == ec) begin
				busy_q <= 1'b0;
			end else begin
				// coefficients below the monic term, old values on the right
				gen_q[0] <= gen_q[0] ^ root_q;
				for (int i = 1; i < MAX_PARITY; i++)
					gen_q[i] <= gen_q[i] ^ gf_mul(root_q, gen_q[i-1]);
				root_q <= gf_xtime(root_q);
				deg_q  <= deg_q + 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign gen  = gen_q;

endmodule

// File: hdl/rspe_lfsr.sv
// input register and parity remainder register, one data word per cycle unless a last word waits for the buffer
// depends on rspe_pkg
module rspe_lfsr import rspe_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  gf_t        in_data,
	input  logic       in_last,
	input  logic       clear,
	input  logic       buf_free,
	input  gf_t        gen [MAX_PARITY],
	output lfsr_stat_t stat,
	output gf_t        par [MAX_PARITY]
);

	logic valid_s1;
	gf_t  data_s1;
	logic last_s1;
	gf_t  rem_q [MAX_PARITY];
	gf_t  rem_n [MAX_PARITY];
	gf_t  fb;
	logic adv;

	// entries at and above the parity count stay zero, so the shift runs full length
	always_comb begin
		fb = data_s1 ^ rem_q[0];
		for (int i = 0; i < MAX_PARITY - 1; i++)
			rem_n[i] = rem_q[i+1] ^ gf_mul(fb, gen[i]);
		rem_n[MAX_PARITY-1] = gf_mul(fb, gen[MAX_PARITY-1]);
	end

	assign stat.stall = valid_s1 && last_s1 && !buf_free;
	assign stat.load  = valid_s1 && last_s1 && buf_free;
	assign adv        = valid_s1 && !stat.stall;
	assign par        = rem_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < MAX_PARITY; i++) rem_q[i] <= '0;
		end else if (clear) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < MAX_PARITY; i++) rem_q[i] <= '0;
		end else begin
			if (in_fire) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) begin
				for (int i = 0; i < MAX_PARITY; i++)
					rem_q[i] <= last_s1 ? gf_t'(0) : rem_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= in_data;
			last_s1 <= in_last;
		end
	end

endmodule

// File: hdl/rspe_outbuf.sv
// parity output buffer, shifts out one word per accepted transfer, highest degree first
// depends on rspe_pkg
module rspe_outbuf import rspe_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  gf_t             par [MAX_PARITY],
	input  logic [EC_W-1:0] ec,
	input  logic            out_ready,
	output logic            out_valid,
	output gf_t             out_data,
	output logic            out_last,
	output logic            buf_free
);

	logic [EC_W-1:0] left_q;
	gf_t             par_q [MAX_PARITY];
	logic            fire;

	assign out_valid = left_q != '0;
	assign out_data  = par_q[0];
	assign out_last  = left_q == EC_W'(1);
	assign fire      = out_valid && out_ready;
	assign buf_free  = !out_valid || (out_last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= ec;
		end else if (fire) begin
			left_q <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			par_q <= par;
		end else if (fire) begin
			for (int i = 0; i < MAX_PARITY - 1; i++) par_q[i] <= par_q[i+1];
			par_q[MAX_PARITY-1] <= '0;
		end
	end

endmodule

// File: hdl/reed_solomon_parity_encoder.sv
// reed-solomon parity encoder over GF(256), field polynomial 0x11D, generator roots alpha^0..
// a last data word waits in the input register until the buffer is free, then its parity loads the output buffer
// throughput: one data word per cycle; n parity words drain at one per accepted transfer, overlapping
// the next block's data (a further last word waits until the buffer drains)
// reset and every ec_count write rebuild the generator one factor at a time, s_tready low
// reset gives ec_count 10 (at most MAX_PARITY), empty remainder and empty output buffer
module reed_solomon_parity_encoder import rspe_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// data word input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_data
	// parity word output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] parity_byte
	output logic        m_tlast    // last_parity
);

	// reset count, saturated to the buffer depth
	localparam int EC_RST = (EC_RESET > MAX_PARITY) ? MAX_PARITY : EC_RESET;

	logic [EC_W-1:0] ec_q;
	logic [EC_W-1:0] ec_wr;
	logic            cfg_wr;
	logic            gen_busy;
	gf_t             gen [MAX_PARITY];
	gf_t             par [MAX_PARITY];
	lfsr_stat_t      stat;
	logic            buf_free;
	logic            in_fire;

	// register write takes the low EC_W bits: zero means one, larger than the buffer saturates
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_EC);

	always_comb begin
		ec_wr = pwdata[EC_W-1:0];
		if (ec_wr == '0) ec_wr = EC_W'(1);
		else if (int'(ec_wr) > MAX_PARITY) ec_wr = EC_W'(MAX_PARITY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q <= EC_W'(EC_RST);
		end else if (cfg_wr) begin
			ec_q <= ec_wr;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EC) ? 32'(ec_q) : 32'd0;

	// input handshake: hold off while the generator is rebuilt or a last word waits
	assign s_tready = !gen_busy && !stat.stall;
	assign in_fire  = s_tvalid && s_tready;

	rspe_genbuild #(
		.MAX_PARITY (MAX_PARITY)
	) u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr),
		.ec     (ec_q),
		.busy   (gen_busy),
		.gen    (gen)
	);

	// remainder update and block end detection
	rspe_lfsr #(
		.MAX_PARITY (MAX_PARITY)
	) u_lfsr (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_data  (s_tdata),
		.in_last  (s_tlast),
		.clear    (cfg_wr),
		.buf_free (buf_free),
		.gen      (gen),
		.stat     (stat),
		.par      (par)
	);

	// parity words leave highest degree first
	rspe_outbuf #(
		.MAX_PARITY (MAX_PARITY)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (stat.load),
		.par       (par),
		.ec        (ec_q),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.buf_free  (buf_free)
	);

endmodule
